### src/x87ss_pkg.sv
// x87ss_pkg: shared types, constants and the status exception function
// of the x87 stack and status controller. No dependencies.
package x87ss_pkg;

   typedef enum logic [2:0] {
      FUNC_PUSH_LOAD  = 3'd0,
      FUNC_STORE      = 3'd1,
      FUNC_ARITH      = 3'd2,
      FUNC_INT_ARITH  = 3'd3,
      FUNC_LOAD_CTRL  = 3'd4,
      FUNC_CLEAR_EXC  = 3'd5
   } func_type;

   // status word bits
   localparam int SW_IE = 0;
   localparam int SW_DE = 1;
   localparam int SW_ZE = 2;
   localparam int SW_OE = 3;
   localparam int SW_UE = 4;
   localparam int SW_PE = 5;
   localparam int SW_SF = 6;
   localparam int SW_ES = 7;
   localparam int SW_C1 = 9;
   localparam int SW_B  = 15;
   localparam int SW_TOP_LSB = 11;

   localparam logic [15:0] SW_EXC_MASK   = 16'h027F;
   localparam logic [15:0] CW_MASKS      = 16'h003F;
   localparam logic [15:0] CW_LOAD_KEEP  = 16'h1F3F;
   localparam logic [15:0] CW_LOAD_SET   = 16'h0040;
   localparam logic [15:0] CW_RESET      = 16'h037F;
   localparam logic [15:0] CLEAR_KEEP    = 16'h7F00;
   localparam logic [15:0] EV_OVERFLOW   = 16'h0241;
   localparam logic [15:0] EV_UNDERFLOW  = 16'h0041;

   typedef struct packed {
      logic [2:0]  func;
      logic        pop_after;
      logic [2:0]  dest_st;
      logic [5:0]  except_flags;
      logic        round_up;
      logic [15:0] new_control;
   } req_type;

   typedef struct packed {
      logic        write_reg;
      logic [2:0]  phys_dest;
      logic        use_nan;
      logic        unmasked_fault;
      logic [15:0] status_out;
      logic [15:0] control_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] status;
      logic        fault;
   } exc_result_type;

   // status update for one exception event against the current words
   function automatic exc_result_type handle_exc(logic [15:0] ev, logic [15:0] sw_in,
                                                 logic [15:0] cw);
      logic [15:0]    e;
      logic [15:0]    sw;
      logic [15:0]    um;
      logic           stop;
      exc_result_type res;
      e    = ev & SW_EXC_MASK;
      sw   = sw_in;
      um   = e & ~cw & CW_MASKS;
      stop = 1'b0;
      if (e[SW_IE] || e[SW_ZE]) begin
         um = um & 16'h0005;
      end
      if (um != 16'h0000) begin
         sw[SW_ES] = 1'b1;
         sw[SW_B]  = 1'b1;
      end
      if (e[SW_IE]) begin
         sw = sw | e;
         if (e[SW_SF] && !e[SW_C1]) begin
            sw[SW_C1] = 1'b0;
         end
      end else if (e[SW_ZE]) begin
         sw[SW_ZE] = 1'b1;
      end else begin
         if (e[SW_DE]) begin
            sw[SW_DE] = 1'b1;
            stop = um[SW_DE];
         end
         if (!stop) begin
            sw = sw | e;
            if (e[SW_PE] && !e[SW_C1]) begin
               sw[SW_C1] = 1'b0;
            end
            um[SW_PE] = 1'b0;
            if (um[SW_UE] || um[SW_OE]) begin
               sw[SW_C1] = 1'b0;
               if (!sw_in[SW_PE]) begin
                  sw[SW_PE] = 1'b0;
               end
            end
         end
      end
      res.status = sw;
      res.fault  = (um != 16'h0000);
      return res;
   endfunction

endpackage

### src/x87ss_if.sv
// x87ss_req_if / x87ss_rsp_if: valid/ready channels of the x87 stack
// and status controller. Depends on x87ss_pkg.
interface x87ss_req_if;
   import x87ss_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

interface x87ss_rsp_if;
   import x87ss_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

### src/x87_stack_status_controller.sv
// x87_stack_status_controller: top level, stack top, tags, status and
// control words. Depends on x87ss_pkg and the channel interfaces.
//
// Usage: instruction events arrive on req_bus (func, pop_after, dest_st,
// except_flags, round_up, new_control). Each accepted word gives exactly one
// rsp_bus word: write permission, physical destination, default-NaN select,
// unmasked fault flag and the status and control words after the event.
// The state and the result register are updated at the accepting edge, and
// the result is valid from the next cycle on.
// Throughput is one word per cycle while the receiver takes each result; the
// event logic over the small state registers sets this figure.
// When the receiver stalls, the result register holds its word and
// req_bus.ready stays high only if that word is taken in the same cycle.
// Synchronous reset empties all tags, sets top and status to zero, loads
// control word 0x037F and drops rsp_bus.valid; ready is low during reset.
module x87_stack_status_controller (
   input  logic         clock,
   input  logic         reset,
   x87ss_req_if.sink    req_bus,
   x87ss_rsp_if.source  rsp_bus
);
   import x87ss_pkg::*;

   logic [2:0]     top_ff, top_in;
   logic [7:0]     busy_ff, busy_in;
   logic [15:0]    status_ff, status_in;
   logic [15:0]    control_ff, control_in;
   logic           out_valid_ff;
   rsp_type        out_ff, out_in;
   logic           accept;
   req_type        rq;
   logic [2:0]     below, rel_dest;
   exc_result_type exc_a, exc_b;
   logic [15:0]    sw_work;
   logic [15:0]    flags_ev;
   logic           empty_top;

   assign req_bus.ready = !reset && (!out_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rq            = req_bus.data;

   assign below     = top_ff - 3'd1;
   assign rel_dest  = top_ff + rq.dest_st;
   assign empty_top = !busy_ff[top_ff];
   assign flags_ev  = {6'd0, rq.round_up, 3'd0, rq.except_flags};

   always_comb begin
      top_in     = top_ff;
      busy_in    = busy_ff;
      status_in  = status_ff;
      control_in = control_ff;
      out_in     = '0;
      sw_work    = status_ff;
      exc_a      = '0;
      exc_b      = '0;
      case (rq.func)
         FUNC_PUSH_LOAD: begin
            sw_work         = status_ff;
            sw_work[SW_C1]  = 1'b0;
            out_in.phys_dest = below;
            exc_a           = handle_exc(EV_OVERFLOW, sw_work, control_ff);
            if (!busy_ff[below]) begin
               top_in          = below;
               busy_in[below]  = 1'b1;
               out_in.write_reg = 1'b1;
               status_in       = sw_work;
            end else begin
               if (control_ff[SW_IE]) begin
                  top_in          = below;
                  busy_in[below]  = 1'b1;
                  out_in.write_reg = 1'b1;
                  out_in.use_nan   = 1'b1;
               end
               status_in             = exc_a.status;
               out_in.unmasked_fault = exc_a.fault;
            end
         end
         FUNC_STORE: begin
            exc_a            = handle_exc(EV_UNDERFLOW, status_ff, control_ff);
            out_in.write_reg = 1'b1;
            out_in.phys_dest = rel_dest;
            if (empty_top) begin
               status_in             = exc_a.status;
               out_in.unmasked_fault = exc_a.fault;
               out_in.use_nan        = 1'b1;
            end
            if (rq.pop_after) begin
               busy_in[top_ff] = 1'b0;
               top_in          = top_ff + 3'd1;
            end
         end
         FUNC_ARITH: begin
            sw_work          = status_ff;
            sw_work[SW_C1]   = 1'b0;
            out_in.phys_dest = rel_dest;
            exc_a            = handle_exc(flags_ev, sw_work, control_ff);
            status_in        = exc_a.status;
            if (exc_a.fault) begin
               out_in.unmasked_fault = 1'b1;
            end else begin
               out_in.write_reg  = 1'b1;
               busy_in[rel_dest] = 1'b1;
               // pop clears the old top after the write tags the destination
               if (rq.pop_after) begin
                  busy_in[top_ff] = 1'b0;
                  top_in          = top_ff + 3'd1;
               end
            end
         end
         FUNC_INT_ARITH: begin
            out_in.phys_dest = top_ff;
            exc_a            = handle_exc(EV_UNDERFLOW, status_ff, control_ff);
            sw_work          = empty_top ? exc_a.status : status_ff;
            exc_b            = handle_exc(flags_ev, sw_work, control_ff);
            status_in        = exc_b.status;
            if (exc_b.fault) begin
               out_in.unmasked_fault = 1'b1;
            end else begin
               out_in.write_reg = 1'b1;
               out_in.use_nan   = empty_top;
               busy_in[top_ff]  = 1'b1;
            end
         end
         FUNC_LOAD_CTRL: begin
            control_in = (rq.new_control & CW_LOAD_KEEP) | CW_LOAD_SET;
            // es and b follow whether a pending exception is now unmasked
            if ((status_ff & ~rq.new_control & CW_MASKS) != 16'h0000) begin
               status_in[SW_ES] = 1'b1;
               status_in[SW_B]  = 1'b1;
            end else begin
               status_in[SW_ES] = 1'b0;
               status_in[SW_B]  = 1'b0;
            end
         end
         FUNC_CLEAR_EXC: begin
            status_in = status_ff & CLEAR_KEEP;
         end
         default: begin
         end
      endcase
      out_in.status_out  = {status_in[15:14], top_in, status_in[10:0]};
      out_in.control_out = control_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= 3'd0;
         busy_ff      <= 8'd0;
         status_ff    <= 16'h0000;
         control_ff   <= CW_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            top_ff       <= top_in;
            busy_ff      <= busy_in;
            status_ff    <= status_in;
            control_ff   <= control_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

endmodule

### src/x87ss_checker.sv
// x87ss_checker: port-level assertions for x87_stack_status_controller,
// bound to the top level. Depends on x87ss_pkg and the channel interfaces.
module x87ss_checker (
   input logic         clock,
   input logic         reset,
   x87ss_req_if.sink   req_bus,
   x87ss_rsp_if.source rsp_bus
);
   import x87ss_pkg::*;

   // every accepted word yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> rsp_bus.valid)
      else $error("no result after accepted word");

   // control word always has bit 6 set and reserved bits clear
   a_control_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.data.control_out[6] && !rsp_bus.data.control_out[7]
                        && (rsp_bus.data.control_out[15:13] == 3'd0))
      else $error("control word shape broken");

   // a default nan is only selected for a write
   a_nan_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.use_nan |-> rsp_bus.data.write_reg)
      else $error("nan select without write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.data))
      else $error("stalled result word changed");

endmodule

bind x87_stack_status_controller x87ss_checker u_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
